// File: design/adsr_envelope_generator_core_assert.svh
// Assertion macros shared by the envelope generator RTL.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ADSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

  localparam logic [2:0] PH_OFF     = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  localparam logic [2:0] REG_START_LEVEL   = 3'd0;
  localparam logic [2:0] REG_ATTACK_TIME   = 3'd1;
  localparam logic [2:0] REG_PEAK_LEVEL    = 3'd2;
  localparam logic [2:0] REG_DECAY_TIME    = 3'd3;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [2:0] REG_RELEASE_TIME  = 3'd5;
  localparam logic [2:0] REG_REST_LEVEL    = 3'd6;

  localparam logic [1:0] SEL_ATTACK  = 2'd0;
  localparam logic [1:0] SEL_DECAY   = 2'd1;
  localparam logic [1:0] SEL_RELEASE = 2'd2;

  localparam logic signed [7:0] START_LEVEL_RESET   = 8'sd0;
  localparam logic signed [7:0] ATTACK_TIME_RESET   = 8'sd1;
  localparam logic signed [7:0] PEAK_LEVEL_RESET    = 8'sd127;
  localparam logic signed [7:0] DECAY_TIME_RESET    = 8'sd1;
  localparam logic signed [7:0] SUSTAIN_LEVEL_RESET = 8'sd100;
  localparam logic signed [7:0] RELEASE_TIME_RESET  = 8'sd1;
  localparam logic signed [7:0] REST_LEVEL_RESET    = 8'sd0;

  localparam logic signed [8:0] ATTACK_STEP_RESET  = 9'sd127;
  localparam logic signed [8:0] DECAY_STEP_RESET   = -9'sd27;
  localparam logic signed [8:0] RELEASE_STEP_RESET = -9'sd100;

  typedef struct packed {
    logic signed [7:0] start_level;
    logic signed [7:0] attack_time;
    logic signed [7:0] peak_level;
    logic signed [7:0] decay_time;
    logic signed [7:0] sustain_level;
    logic signed [7:0] release_time;
    logic signed [7:0] rest_level;
  } adsr_cfg_t;

  typedef struct packed {
    logic signed [8:0] attack_step;
    logic signed [8:0] decay_step;
    logic signed [8:0] release_step;
  } adsr_steps_t;

  typedef struct packed {
    logic [2:0]        phase;
    logic signed [7:0] level;
  } adsr_env_t;

endpackage

// File: design/adsr_step_divider.sv
`timescale 1ns / 1ps

module adsr_step_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  adsr_pkg::adsr_cfg_t   cfg,
  output logic               busy,
  output adsr_pkg::adsr_steps_t steps
);
  import adsr_pkg::*;

  localparam logic [1:0] DIV_IDLE = 2'd0;
  localparam logic [1:0] DIV_LOAD = 2'd1;
  localparam logic [1:0] DIV_RUN  = 2'd2;
  localparam logic [1:0] DIV_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] sel;
  logic [2:0] count;
  logic [7:0] quo;
  logic [6:0] rem;
  logic [6:0] divisor;
  logic       neg;
  logic       up;

  logic signed [7:0] op_from;
  logic signed [7:0] op_to;
  logic signed [7:0] op_ticks;
  logic signed [8:0] diff;
  logic [8:0]        mag_full;
  logic [6:0]        ticks_eff;
  logic [7:0]        trial;
  logic              fits;
  logic [7:0]        trial_sub;
  logic [8:0]        q_mag;
  logic signed [8:0] q_signed;
  logic signed [8:0] result;

  always_comb begin
    case (sel)
      SEL_ATTACK: begin
        op_from  = cfg.start_level;
        op_to    = cfg.peak_level;
        op_ticks = cfg.attack_time;
      end
      SEL_DECAY: begin
        op_from  = cfg.peak_level;
        op_to    = cfg.sustain_level;
        op_ticks = cfg.decay_time;
      end
      default: begin
        op_from  = cfg.sustain_level;
        op_to    = cfg.rest_level;
        op_ticks = cfg.release_time;
      end
    endcase
  end

  assign diff      = {op_to[7], op_to} - {op_from[7], op_from};
  assign mag_full  = diff[8] ? (~diff + 9'd1) : diff;
  assign ticks_eff = (op_ticks[7] || op_ticks == 8'sd0) ? 7'd1 : op_ticks[6:0];

  assign trial     = {rem, quo[7]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};

  assign q_mag    = {1'b0, quo};
  assign q_signed = neg ? -q_mag : q_mag;
  assign result   = (quo == 8'd0) ? (up ? 9'sd1 : -9'sd1) : q_signed;

  assign busy = state != DIV_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= DIV_IDLE;
      sel                <= SEL_ATTACK;
      count              <= 3'd0;
      steps.attack_step  <= ATTACK_STEP_RESET;
      steps.decay_step   <= DECAY_STEP_RESET;
      steps.release_step <= RELEASE_STEP_RESET;
    end else if (start) begin
      state <= DIV_LOAD;
      sel   <= SEL_ATTACK;
    end else begin
      case (state)
        DIV_LOAD: begin
          quo     <= mag_full[7:0];
          rem     <= 7'd0;
          divisor <= ticks_eff;
          neg     <= diff[8];
          up      <= !diff[8] && (diff != 9'sd0);
          count   <= 3'd0;
          state   <= DIV_RUN;
        end
        DIV_RUN: begin
          rem   <= fits ? trial_sub[6:0] : trial[6:0];
          quo   <= {quo[6:0], fits};
          count <= count + 3'd1;
          if (count == 3'd7) begin
            state <= DIV_DONE;
          end
        end
        DIV_DONE: begin
          case (sel)
            SEL_ATTACK: steps.attack_step <= result;
            SEL_DECAY:  steps.decay_step  <= result;
            default:    steps.release_step <= result;
          endcase
          if (sel == SEL_RELEASE) begin
            state <= DIV_IDLE;
          end else begin
            sel   <= sel + 2'd1;
            state <= DIV_LOAD;
          end
        end
        default: begin
          state <= DIV_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/adsr_segment_logic.sv
`timescale 1ns / 1ps

module adsr_segment_logic (
  input  adsr_pkg::adsr_cfg_t   cfg,
  input  adsr_pkg::adsr_steps_t steps,
  input  adsr_pkg::adsr_env_t   cur,
  input  logic [7:0]            prev_gate,
  input  logic [7:0]            gate,
  output adsr_pkg::adsr_env_t   nxt
);
  import adsr_pkg::*;

  logic              trigger;
  logic [2:0]        phase_mid;
  logic signed [7:0] level_mid;
  logic signed [7:0] target;
  logic signed [8:0] step;
  logic [2:0]        phase_done;
  logic              moving;
  logic signed [9:0] level_wide;
  logic signed [9:0] step_wide;
  logic signed [9:0] limit;
  logic signed [9:0] sum;
  logic              snap;

  assign trigger = (gate != 8'd0) &&
                   (cur.phase == PH_OFF || cur.phase == PH_RELEASE || gate != prev_gate);

  always_comb begin
    if (trigger) begin
      phase_mid = PH_ATTACK;
      level_mid = cfg.start_level;
    end else if (gate == 8'd0) begin
      phase_mid = PH_RELEASE;
      level_mid = cur.level;
    end else begin
      phase_mid = cur.phase;
      level_mid = cur.level;
    end
  end

  always_comb begin
    moving = 1'b1;
    case (phase_mid)
      PH_ATTACK: begin
        target     = cfg.peak_level;
        step       = steps.attack_step;
        phase_done = PH_DECAY;
      end
      PH_DECAY: begin
        target     = cfg.sustain_level;
        step       = steps.decay_step;
        phase_done = PH_SUSTAIN;
      end
      PH_RELEASE: begin
        target     = cfg.rest_level;
        step       = steps.release_step;
        phase_done = PH_OFF;
      end
      default: begin
        moving     = 1'b0;
        target     = cfg.rest_level;
        step       = steps.release_step;
        phase_done = phase_mid;
      end
    endcase
  end

  assign level_wide = {{2{level_mid[7]}}, level_mid};
  assign step_wide  = {step[8], step};
  assign limit      = {{2{target[7]}}, target} - step_wide;
  assign sum        = level_wide + step_wide;
  assign snap       = step[8] ? (level_wide <= limit) : (level_wide >= limit);

  always_comb begin
    if (!moving) begin
      nxt.phase = phase_mid;
      nxt.level = level_mid;
    end else if (snap) begin
      nxt.phase = phase_done;
      nxt.level = target;
    end else begin
      nxt.phase = phase_mid;
      nxt.level = sum[7:0];
    end
  end

endmodule

// File: design/adsr_envelope_generator_core.sv
`timescale 1ns / 1ps
// A tick is registered on acceptance and its result is registered once out_stall allows.
// Throughput: one tick per cycle while neither out_stall, a register write nor a step update holds the input.
// A register write recomputes the three steps in a shared bit-serial divider,
// and in_stall is held high while it runs.
// Reset (rst, synchronous, active high) restores register defaults, the envelope to off.
module adsr_envelope_generator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        gate_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] level,
  output logic [2:0]        phase,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);
  import adsr_pkg::*;

  `include "adsr_envelope_generator_core_assert.svh"

  adsr_cfg_t   cfg;
  adsr_steps_t steps;
  adsr_env_t   env;
  adsr_env_t   env_next;
  logic [7:0]  prev_gate;
  logic        in_reg_valid;
  logic [7:0]  in_gate;
  logic        div_busy;
  logic        cfg_start;
  logic        process;
  logic        steps_nonzero;

  assign cfg_start = cfg_write_en && (cfg_index <= REG_REST_LEVEL);
  assign process   = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall  = div_busy || cfg_write_en || (in_reg_valid && !process);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_level   <= START_LEVEL_RESET;
      cfg.attack_time   <= ATTACK_TIME_RESET;
      cfg.peak_level    <= PEAK_LEVEL_RESET;
      cfg.decay_time    <= DECAY_TIME_RESET;
      cfg.sustain_level <= SUSTAIN_LEVEL_RESET;
      cfg.release_time  <= RELEASE_TIME_RESET;
      cfg.rest_level    <= REST_LEVEL_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_START_LEVEL:   cfg.start_level   <= cfg_data;
        REG_ATTACK_TIME:   cfg.attack_time   <= cfg_data;
        REG_PEAK_LEVEL:    cfg.peak_level    <= cfg_data;
        REG_DECAY_TIME:    cfg.decay_time    <= cfg_data;
        REG_SUSTAIN_LEVEL: cfg.sustain_level <= cfg_data;
        REG_RELEASE_TIME:  cfg.release_time  <= cfg_data;
        REG_REST_LEVEL:    cfg.rest_level    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  adsr_step_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_start),
    .cfg   (cfg),
    .busy  (div_busy),
    .steps (steps)
  );

  adsr_segment_logic u_segment (
    .cfg       (cfg),
    .steps     (steps),
    .cur       (env),
    .prev_gate (prev_gate),
    .gate      (in_gate),
    .nxt       (env_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_reg_valid <= 1'b1;
    end else if (process) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_gate <= gate_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env.phase <= PH_OFF;
      env.level <= REST_LEVEL_RESET;
      prev_gate <= 8'd0;
    end else if (process) begin
      env       <= env_next;
      prev_gate <= in_gate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      level <= env_next.level;
      phase <= env_next.phase;
    end
  end

  assign steps_nonzero = (steps.attack_step != 9'sd0) && (steps.decay_step != 9'sd0) &&
                         (steps.release_step != 9'sd0);

  `ADSR_ASSERT_SAME(a_busy_stalls_input, clk, rst, div_busy, in_stall, "input taken while busy")
  `ADSR_ASSERT_NEXT(a_write_starts_update, clk, rst, cfg_start, div_busy, "no step update")
  `ADSR_ASSERT_NEXT(a_process_gives_result, clk, rst, process, out_valid, "no result for tick")
  `ADSR_ASSERT_SAME(a_steps_nonzero, clk, rst, 1'b1, steps_nonzero, "zero envelope step")

endmodule
